@@ rtl/bdq_pkg.sv @@
// Shared types and codes for the bounded double-ended queue.
// Used by bdq_store and bounded_deque; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int unsigned WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    word_t      value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    word_t      front_value;
    word_t      back_value;
    logic [4:0] count;
    logic       is_empty;
    logic       is_full;
  } out_t;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_e;

endpackage

`default_nettype wire

@@ rtl/bdq_store.sv @@
// Word storage of the queue: one write port and one read port with registered data.
// Depends on bdq_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none

module bdq_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire               clk_i,
  input  wire               we_i,
  input  wire  [AW-1:0]     waddr_i,
  input  bdq_pkg::word_t    wdata_i,
  input  wire               re_i,
  input  wire  [AW-1:0]     raddr_i,
  output bdq_pkg::word_t    rdata_o
);
  import bdq_pkg::*;

  word_t mem_q [DEPTH];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/bounded_deque.sv @@
// Bounded double-ended queue of signed words, kept as a ring in one synchronous memory.
// Pushes, clear, refused operations and pops that leave the queue empty finish in S_IDLE
// and allow one item per cycle unless the output stalls; other pops wait in S_FETCH for the
// read data. The result is registered, in the cycle after acceptance at the earliest.
// Reset empties the queue at once; no memory clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_stall_o,
  input  bdq_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  wire           out_stall_i,
  output bdq_pkg::out_t out_o
);
  import bdq_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e        state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  word_t         front_q, front_d;
  word_t         back_q, back_d;
  logic          pend_front_q, pend_front_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  logic          in_accept;
  logic          out_free;
  logic          out_load;
  logic [1:0]    status;
  logic          is_full;
  logic          is_empty;
  logic [IW-1:0] head_inc;
  logic [IW-1:0] head_dec;
  logic [CW-1:0] tail_off;
  logic [IW:0]   tail_sum;
  logic [IW-1:0] tail_idx;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  word_t         mem_rdata;

  bdq_store #(
    .DEPTH(CAPACITY),
    .AW   (IW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(in_i.value),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == CW'(CAPACITY));
  assign is_empty = (count_q == '0);

  assign head_inc = (head_q == IW'(CAPACITY - 1)) ? '0 : head_q + IW'(1);
  assign head_dec = (head_q == '0) ? IW'(CAPACITY - 1) : head_q - IW'(1);

  assign tail_off = (in_i.operation == OP_PUSH_BACK) ? count_q : count_q - CW'(2);
  assign tail_sum = {1'b0, head_q} + (IW+1)'(tail_off);
  assign tail_idx = (tail_sum >= (IW+1)'(CAPACITY)) ?
                    IW'(tail_sum - (IW+1)'(CAPACITY)) : IW'(tail_sum);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    front_d      = front_q;
    back_d       = back_q;
    pend_front_d = pend_front_q;
    status       = ST_DONE;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = tail_idx;
    mem_re       = 1'b0;
    mem_raddr    = tail_idx;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          out_load = 1'b1;
          case (in_i.operation)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                status = ST_FULL;
              end else begin
                head_d    = head_dec;
                count_d   = count_q + CW'(1);
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                front_d   = in_i.value;
                if (is_empty) begin
                  back_d = in_i.value;
                end
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                status = ST_FULL;
              end else begin
                count_d = count_q + CW'(1);
                mem_we  = 1'b1;
                back_d  = in_i.value;
                if (is_empty) begin
                  front_d = in_i.value;
                end
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                status = ST_EMPTY;
              end else begin
                head_d  = head_inc;
                count_d = count_q - CW'(1);
                if (count_q == CW'(1)) begin
                  front_d = '0;
                  back_d  = '0;
                end else begin
                  mem_re       = 1'b1;
                  mem_raddr    = head_inc;
                  pend_front_d = 1'b1;
                  out_load     = 1'b0;
                  state_d      = S_FETCH;
                end
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                status = ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                if (count_q == CW'(1)) begin
                  front_d = '0;
                  back_d  = '0;
                end else begin
                  mem_re       = 1'b1;
                  pend_front_d = 1'b0;
                  out_load     = 1'b0;
                  state_d      = S_FETCH;
                end
              end
            end
            OP_CLEAR: begin
              head_d  = '0;
              count_d = '0;
              front_d = '0;
              back_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        if (out_free) begin
          if (pend_front_q) begin
            front_d = mem_rdata;
          end else begin
            back_d = mem_rdata;
          end
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_d.status      = status;
    out_d.front_value = front_d;
    out_d.back_value  = back_d;
    out_d.count       = 5'(count_d);
    out_d.is_empty    = (count_d == '0);
    out_d.is_full     = (count_d == CW'(CAPACITY));

    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      front_q      <= '0;
      back_q       <= '0;
      pend_front_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      front_q      <= front_d;
      back_q       <= back_d;
      pend_front_q <= pend_front_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire
